/* hw/rtl/assert_macros.svh */
// Assertion macros used by dsmt_core, the datapath of the start match timer.
// No dependencies; simulation only, empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* hw/rtl/dsmt_pkg.sv */
// Package for the debounced start match timer: types, constants, codes.
// No dependencies.
`default_nettype none

package dsmt_pkg;

	localparam int TIMEOUT_WIDTH_DEF = 16;
	localparam int ELAPSED_WIDTH_DEF = 24;

	localparam int LIMIT_W  = 8;
	localparam int LENGTH_W = 24;
	localparam int FIELD_W  = 16;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [LIMIT_W-1:0]  DEBOUNCE_LIMIT_RST = 8'd30;
	localparam logic [LENGTH_W-1:0] MATCH_LENGTH_RST   = 24'd90000;

	// register index, taken from paddr[2]
	localparam logic REG_DEBOUNCE_LIMIT = 1'b0;
	localparam logic REG_MATCH_LENGTH   = 1'b1;

	typedef enum logic [1:0] {
		CMD_TICK       = 2'd0,
		CMD_LOAD_SEQ   = 2'd1,
		CMD_LOAD_SHORT = 2'd2,
		CMD_LOAD_SERVO = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  debounce_limit;
		logic [LENGTH_W-1:0] match_length;
	} cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/dsmt_cfg.sv */
// APB register file: debounce limit and match length.
// Depends on dsmt_pkg.
`default_nettype none

module dsmt_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dsmt_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [dsmt_pkg::PDATA_W-1:0]  pwdata,
	output logic      [dsmt_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output dsmt_pkg::cfg_t                     cfg
);

	logic [dsmt_pkg::LIMIT_W-1:0]  limit_q;
	logic [dsmt_pkg::LENGTH_W-1:0] length_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= dsmt_pkg::DEBOUNCE_LIMIT_RST;
			length_q <= dsmt_pkg::MATCH_LENGTH_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				dsmt_pkg::REG_DEBOUNCE_LIMIT: limit_q  <= pwdata[dsmt_pkg::LIMIT_W-1:0];
				dsmt_pkg::REG_MATCH_LENGTH:   length_q <= pwdata[dsmt_pkg::LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dsmt_pkg::REG_DEBOUNCE_LIMIT:
				prdata = dsmt_pkg::PDATA_W'(limit_q);
			dsmt_pkg::REG_MATCH_LENGTH:
				prdata = dsmt_pkg::PDATA_W'(length_q);
			default:
				prdata = '0;
		endcase
	end

	assign cfg.debounce_limit = limit_q;
	assign cfg.match_length   = length_q;

endmodule

`default_nettype wire

/* hw/rtl/dsmt_core.sv */
// Item datapath: input register, debounce/match/countdown update, result register.
// Depends on dsmt_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dsmt_core #(
	parameter int TIMEOUT_WIDTH = dsmt_pkg::TIMEOUT_WIDTH_DEF,
	parameter int ELAPSED_WIDTH = dsmt_pkg::ELAPSED_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dsmt_pkg::cfg_t                cfg,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [1:0]                    command,
	input  wire logic                          cord_level,
	input  wire logic [dsmt_pkg::FIELD_W-1:0]  load_value,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic                               start_pulse,
	output logic                               end_pulse,
	output logic                               motion_stop,
	output logic                               match_over,
	output logic                               armed,
	output logic      [dsmt_pkg::FIELD_W-1:0]  sequence_remaining,
	output logic                               short_running,
	output logic      [dsmt_pkg::FIELD_W-1:0]  servo_delay_remaining
);

	localparam int TW = TIMEOUT_WIDTH;
	localparam int EW = ELAPSED_WIDTH;

	// input stage
	logic                         valid_s1;
	logic [1:0]                   command_s1;
	logic                         cord_s1;
	logic [dsmt_pkg::FIELD_W-1:0] load_s1;

	// result stage
	logic                         valid_s2;
	logic                         start_s2, end_s2, stop_s2, over_s2, armed_s2, short_s2;
	logic [dsmt_pkg::FIELD_W-1:0] seq_s2, servo_s2;

	// block state
	logic [dsmt_pkg::LIMIT_W-1:0] cnt_q, cnt_n;
	logic                         armed_q, armed_n;
	logic                         active_q, active_n;
	logic [EW-1:0]                el_q, el_n;
	logic                         over_q, over_n;
	logic [TW-1:0]                seq_q, seq_n;
	logic [TW-1:0]                sht_q, sht_n;
	logic [TW-1:0]                srv_q, srv_n;

	logic                         advance;
	logic                         step;
	logic                         start_c, end_c, stop_c;
	logic [31:0]                  load_ext, el_ext, len_ext, seq_ext, srv_ext;
	logic [TW-1:0]                load_t;

	assign advance    = !valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			command_s1 <= command;
			cord_s1    <= cord_level;
			load_s1    <= load_value;
		end
	end

	always_comb begin
		cnt_n    = cnt_q;
		armed_n  = armed_q;
		active_n = active_q;
		el_n     = el_q;
		over_n   = over_q;
		seq_n    = seq_q;
		sht_n    = sht_q;
		srv_n    = srv_q;
		start_c  = 1'b0;
		end_c    = 1'b0;
		stop_c   = 1'b0;
		el_ext   = '0;
		len_ext  = 32'(cfg.match_length);
		load_ext = 32'(load_s1);
		load_t   = load_ext[TW-1:0];
		unique case (dsmt_pkg::cmd_t'(command_s1))
			dsmt_pkg::CMD_LOAD_SEQ:   seq_n = load_t;
			dsmt_pkg::CMD_LOAD_SHORT: sht_n = load_t;
			dsmt_pkg::CMD_LOAD_SERVO: srv_n = load_t;
			dsmt_pkg::CMD_TICK: begin
				if (cord_s1) begin
					if (cnt_q < cfg.debounce_limit)
						cnt_n = cnt_q + 8'd1;
				end else if (cnt_q != '0) begin
					cnt_n = cnt_q - 8'd1;
				end

				if (armed_q) begin
					if (cnt_n == '0) begin
						armed_n  = 1'b0;
						active_n = 1'b1;
						el_n     = '0;
						start_c  = 1'b1;
					end
				end else if (cnt_n >= cfg.debounce_limit) begin
					armed_n  = 1'b1;
					active_n = 1'b0;
					el_n     = '0;
				end

				srv_n = (srv_q != '0) ? srv_q - TW'(1) : '0;
				seq_n = (seq_q != '0) ? seq_q - TW'(1) : '0;
				sht_n = (sht_q != '0) ? sht_q - TW'(1) : '0;

				el_ext = 32'(el_n);
				if (el_ext < len_ext) begin
					el_n   = active_n ? el_n + EW'(1) : '0;
					over_n = 1'b0;
				end else if (el_ext == len_ext) begin
					el_n   = el_n + EW'(1);
					end_c  = 1'b1;
					over_n = 1'b1;
				end else begin
					stop_c = 1'b1;
					over_n = 1'b1;
					if (!active_n)
						el_n = '0;
				end
			end
			default: ;
		endcase
		seq_ext = 32'(seq_n);
		srv_ext = 32'(srv_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			armed_q  <= 1'b0;
			active_q <= 1'b0;
			el_q     <= '0;
			over_q   <= 1'b0;
			seq_q    <= '0;
			sht_q    <= '0;
			srv_q    <= '0;
		end else if (step) begin
			cnt_q    <= cnt_n;
			armed_q  <= armed_n;
			active_q <= active_n;
			el_q     <= el_n;
			over_q   <= over_n;
			seq_q    <= seq_n;
			sht_q    <= sht_n;
			srv_q    <= srv_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			start_s2 <= start_c;
			end_s2   <= end_c;
			stop_s2  <= stop_c;
			over_s2  <= over_n;
			armed_s2 <= armed_n;
			seq_s2   <= seq_ext[dsmt_pkg::FIELD_W-1:0];
			short_s2 <= (sht_n != '0);
			servo_s2 <= srv_ext[dsmt_pkg::FIELD_W-1:0];
		end
	end

	assign result_valid          = valid_s2;
	assign start_pulse           = start_s2;
	assign end_pulse             = end_s2;
	assign motion_stop           = stop_s2;
	assign match_over            = over_s2;
	assign armed                 = armed_s2;
	assign sequence_remaining    = seq_s2;
	assign short_running         = short_s2;
	assign servo_delay_remaining = servo_s2;

	`ASSERT_NEVER(a_start_while_armed, clk, arst_n, valid_s2 && start_s2 && armed_s2)
	`ASSERT_NEVER(a_end_and_stop, clk, arst_n, valid_s2 && end_s2 && stop_s2)
	`ASSERT_ALWAYS(a_over_flag, clk, arst_n, valid_s2 && (end_s2 || stop_s2) |-> over_s2)
	`ASSERT_ALWAYS(a_stall_holds, clk, arst_n, valid_s1 && !advance |=> valid_s1 && $stable(command_s1))
	`ASSERT_ALWAYS(a_start_clears_count, clk, arst_n, step && start_c |=> el_q == '0 || el_q == EW'(1))

endmodule

`default_nettype wire

/* hw/rtl/debounced_start_match_timer_unit.sv */
// Debounced start match timer: one transaction in, one result transaction out.
// An accepted transaction goes through the input register and the update pass into the result register.
// Throughput: one transaction per cycle absent back-pressure; input register, one update pass, result register.
// Back-pressure on the result side stalls both stages; item_ready drops only then.
// Reset (arst_n low, asynchronous): all timer state zero, limit 30, match length 90000.
// Depends on dsmt_pkg, dsmt_cfg and dsmt_core.
`default_nettype none

module debounced_start_match_timer_unit #(
	parameter int TIMEOUT_WIDTH = dsmt_pkg::TIMEOUT_WIDTH_DEF,
	parameter int ELAPSED_WIDTH = dsmt_pkg::ELAPSED_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dsmt_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [dsmt_pkg::PDATA_W-1:0]  pwdata,
	output logic      [dsmt_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [1:0]                    command,
	input  wire logic                          cord_level,
	input  wire logic [dsmt_pkg::FIELD_W-1:0]  load_value,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic                               start_pulse,
	output logic                               end_pulse,
	output logic                               motion_stop,
	output logic                               match_over,
	output logic                               armed,
	output logic      [dsmt_pkg::FIELD_W-1:0]  sequence_remaining,
	output logic                               short_running,
	output logic      [dsmt_pkg::FIELD_W-1:0]  servo_delay_remaining
);

	dsmt_pkg::cfg_t cfg;

	dsmt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dsmt_core #(
		.TIMEOUT_WIDTH (TIMEOUT_WIDTH),
		.ELAPSED_WIDTH (ELAPSED_WIDTH)
	) u_core (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cfg                   (cfg),
		.item_valid            (item_valid),
		.item_ready            (item_ready),
		.command               (command),
		.cord_level            (cord_level),
		.load_value            (load_value),
		.result_valid          (result_valid),
		.result_ready          (result_ready),
		.start_pulse           (start_pulse),
		.end_pulse             (end_pulse),
		.motion_stop           (motion_stop),
		.match_over            (match_over),
		.armed                 (armed),
		.sequence_remaining    (sequence_remaining),
		.short_running         (short_running),
		.servo_delay_remaining (servo_delay_remaining)
	);

endmodule

`default_nettype wire
